// ===== rtl/core/shtp_pkg.sv =====
// ----------------------------------------------------------------------------
// String hash table probe: shared package
// Widths, codes, the request format between front and back, and the crypt
// tables that are generated at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package shtp_pkg;

  localparam int HASH_W      = 32;
  localparam int SLOT_W      = 10;
  localparam int STATUS_W    = 3;
  localparam int BYTE_W      = 8;
  localparam int NUM_HASHES  = 3;
  localparam int CRYPT_CHARS = 'h100;
  localparam int CRYPT_KINDS = 4;

  localparam logic [HASH_W-1:0] SEED1_INIT      = 32'h7FED7FED;
  localparam logic [HASH_W-1:0] SEED2_INIT      = 32'hEEEEEEEE;
  localparam logic [HASH_W-1:0] MIX_INC         = 32'd3;
  localparam longint unsigned   CRYPT_START     = 64'h00100001;
  localparam longint unsigned   CRYPT_MUL       = 64'd125;
  localparam longint unsigned   CRYPT_INC       = 64'd3;
  localparam longint unsigned   CRYPT_MOD       = 64'h2AAAAB;
  localparam longint unsigned   CRYPT_HALF_MASK = 64'hFFFF;

  // Hash lanes inside the front.
  localparam int LANE_A    = 0;
  localparam int LANE_B    = 1;
  localparam int LANE_SLOT = 2;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND      = 3'd0,
    STATUS_INSERTED   = 3'd1,
    STATUS_NOT_FOUND  = 3'd2,
    STATUS_FULL       = 3'd3,
    STATUS_EMPTY_NAME = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic              empty_name;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
    logic [HASH_W-1:0] hash_slot;
  } req_t;

  typedef logic [CRYPT_CHARS-1:0][HASH_W-1:0] crypt_tab_t;

  // Runs the table generator and keeps the words of one kind.
  function automatic crypt_tab_t crypt_gen(input int kind);
    crypt_tab_t      tab;
    longint unsigned s;
    longint unsigned hi;
    longint unsigned lo;
    tab = '0;
    s   = CRYPT_START;
    for (int c = 0; c < CRYPT_CHARS; c++) begin
      for (int k = 0; k < CRYPT_KINDS; k++) begin
        s  = (s * CRYPT_MUL + CRYPT_INC) % CRYPT_MOD;
        hi = s & CRYPT_HALF_MASK;
        s  = (s * CRYPT_MUL + CRYPT_INC) % CRYPT_MOD;
        lo = s & CRYPT_HALF_MASK;
        if (k == kind) begin
          tab[c] = {hi[15:0], lo[15:0]};
        end
      end
    end
    return tab;
  endfunction

  localparam crypt_tab_t CRYPT_A    = crypt_gen(1);
  localparam crypt_tab_t CRYPT_B    = crypt_gen(2);
  localparam crypt_tab_t CRYPT_SLOT = crypt_gen(3);

endpackage

`default_nettype wire

// ===== rtl/core/string_hash_table_probe.sv =====
// ----------------------------------------------------------------------------
// String hash table probe: top level
// Hashes names byte by byte and looks up or inserts them in a hash table.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                      Handshake
//   input     in_opcode, in_name_byte, in_last           in_push / in_full
//   result    out_status, out_slot, out_slot_hash,       out_empty / out_pop
//             out_check_hash_a, out_check_hash_b
//
// A byte that does not end a name only updates the hashes in the front.
// A non-empty name end leaves the queue, then goes through remainder reduction,
// a table scan through the single table read port, and a result load.
// After reset the valid marks are cleared with in_full high.
// Two name ends can wait in the queue; in_full rises when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module string_hash_table_probe #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic                              in_opcode,
  input  wire logic [shtp_pkg::BYTE_W-1:0]       in_name_byte,
  input  wire logic                              in_last,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic [shtp_pkg::STATUS_W-1:0]          out_status,
  output logic [shtp_pkg::SLOT_W-1:0]            out_slot,
  output logic [shtp_pkg::HASH_W-1:0]            out_slot_hash,
  output logic [shtp_pkg::HASH_W-1:0]            out_check_hash_a,
  output logic [shtp_pkg::HASH_W-1:0]            out_check_hash_b
);

  logic           in_acc;
  logic           req_push;
  shtp_pkg::req_t req_data;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  shtp_pkg::req_t q_data;
  logic           clearing;

  assign in_full = q_full || clearing;
  assign in_acc  = in_push && !in_full;

  shtp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_acc       (in_acc),
    .in_opcode    (in_opcode),
    .in_name_byte (in_name_byte),
    .in_last      (in_last),
    .req_push     (req_push),
    .req_data     (req_data)
  );

  shtp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_push),
    .push_data (req_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  shtp_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_slot_hash    (out_slot_hash),
    .out_check_hash_a (out_check_hash_a),
    .out_check_hash_b (out_check_hash_b)
  );

endmodule

`default_nettype wire

// ===== rtl/core/shtp_front.sv =====
// ----------------------------------------------------------------------------
// String hash table probe: front
// Hashes each byte into three seeded hashes and hands a request to the
// queue when a name ends.
// ----------------------------------------------------------------------------
`default_nettype none

module shtp_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_acc,
  input  wire logic                          in_opcode,
  input  wire logic [shtp_pkg::BYTE_W-1:0]   in_name_byte,
  input  wire logic                          in_last,
  output logic                               req_push,
  output shtp_pkg::req_t                     req_data
);

  logic [shtp_pkg::HASH_W-1:0] s1_r   [shtp_pkg::NUM_HASHES];
  logic [shtp_pkg::HASH_W-1:0] s2_r   [shtp_pkg::NUM_HASHES];
  logic [shtp_pkg::HASH_W-1:0] s1_mix [shtp_pkg::NUM_HASHES];
  logic [shtp_pkg::HASH_W-1:0] s2_mix [shtp_pkg::NUM_HASHES];
  logic [shtp_pkg::HASH_W-1:0] rom_word [shtp_pkg::NUM_HASHES];
  logic [shtp_pkg::HASH_W-1:0] s1_new [shtp_pkg::NUM_HASHES];
  logic                        seen_r;
  logic                        byte_nz;

  assign byte_nz = (in_name_byte != '0);

  assign rom_word[shtp_pkg::LANE_A]    = shtp_pkg::CRYPT_A[in_name_byte];
  assign rom_word[shtp_pkg::LANE_B]    = shtp_pkg::CRYPT_B[in_name_byte];
  assign rom_word[shtp_pkg::LANE_SLOT] = shtp_pkg::CRYPT_SLOT[in_name_byte];

  always_comb begin
    for (int i = 0; i < shtp_pkg::NUM_HASHES; i++) begin
      s1_mix[i] = rom_word[i] ^ (s1_r[i] + s2_r[i]);
      s2_mix[i] = {{(shtp_pkg::HASH_W-shtp_pkg::BYTE_W){1'b0}}, in_name_byte}
                + s1_mix[i] + s2_r[i] + (s2_r[i] << 5) + shtp_pkg::MIX_INC;
      // A zero byte leaves the hashes untouched.
      s1_new[i] = byte_nz ? s1_mix[i] : s1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < shtp_pkg::NUM_HASHES; i++) begin
        s1_r[i] <= shtp_pkg::SEED1_INIT;
        s2_r[i] <= shtp_pkg::SEED2_INIT;
      end
      seen_r <= 1'b0;
    end else if (in_acc) begin
      if (in_last) begin
        for (int i = 0; i < shtp_pkg::NUM_HASHES; i++) begin
          s1_r[i] <= shtp_pkg::SEED1_INIT;
          s2_r[i] <= shtp_pkg::SEED2_INIT;
        end
        seen_r <= 1'b0;
      end else if (byte_nz) begin
        for (int i = 0; i < shtp_pkg::NUM_HASHES; i++) begin
          s1_r[i] <= s1_mix[i];
          s2_r[i] <= s2_mix[i];
        end
        seen_r <= 1'b1;
      end
    end
  end

  assign req_push            = in_acc && in_last;
  assign req_data.op         = shtp_pkg::op_t'(in_opcode);
  assign req_data.empty_name = !(seen_r || byte_nz);
  assign req_data.hash_a     = s1_new[shtp_pkg::LANE_A];
  assign req_data.hash_b     = s1_new[shtp_pkg::LANE_B];
  assign req_data.hash_slot  = s1_new[shtp_pkg::LANE_SLOT];

endmodule

`default_nettype wire

// ===== rtl/core/shtp_queue.sv =====
// ----------------------------------------------------------------------------
// String hash table probe: request queue
// Two-entry queue that decouples the hashing front from the table back.
// ----------------------------------------------------------------------------
`default_nettype none

module shtp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire shtp_pkg::req_t push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output shtp_pkg::req_t      pop_data
);

  shtp_pkg::req_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/shtp_back.sv =====
// ----------------------------------------------------------------------------
// String hash table probe: back
// Reduces the slot hash to a start position, scans the table at most once,
// stopping at a hit, claims the first free entry on an insert miss, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module shtp_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  input  wire shtp_pkg::req_t                   q_data,
  output logic                                  q_pop,
  output logic                                  clearing,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [shtp_pkg::STATUS_W-1:0]         out_status,
  output logic [shtp_pkg::SLOT_W-1:0]           out_slot,
  output logic [shtp_pkg::HASH_W-1:0]           out_slot_hash,
  output logic [shtp_pkg::HASH_W-1:0]           out_check_hash_a,
  output logic [shtp_pkg::HASH_W-1:0]           out_check_hash_b
);

  localparam int         PW        = $clog2(TABLE_DEPTH);
  localparam logic [PW:0] DEPTH_W  = (PW+1)'(TABLE_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(TABLE_DEPTH - 1);
  localparam logic [PW:0] CNT_LAST = (PW+1)'(TABLE_DEPTH - 1);
  localparam logic [1:0]  MOD_LAST = 2'd2;
  localparam logic [shtp_pkg::HASH_W-1:0] DEPTH_32 = 32'(TABLE_DEPTH);
  // Depth reciprocal scaled by 2^32; the quotient estimate is at most one low.
  localparam logic [shtp_pkg::HASH_W-1:0] RECIP = 32'((64'd1 << 32) / TABLE_DEPTH);

  // Table storage: valid marks are swept clear after reset, check words are not.
  logic                           vld_mem [TABLE_DEPTH];
  logic [2*shtp_pkg::HASH_W-1:0]  chk_mem [TABLE_DEPTH];
  logic                           vld_q;
  logic [2*shtp_pkg::HASH_W-1:0]  chk_q;

  shtp_pkg::back_state_t state_r, state_nxt;

  shtp_pkg::req_t             job_r;
  logic [PW-1:0]              clr_addr_r;
  logic [1:0]                 mod_cnt_r;
  logic [shtp_pkg::HASH_W-1:0] mod_src_r;
  logic [2*shtp_pkg::HASH_W-1:0] mod_prod_r;
  logic [shtp_pkg::HASH_W-1:0] mod_qd_r;
  logic [shtp_pkg::HASH_W-1:0] mod_rem;
  logic [shtp_pkg::HASH_W-1:0] mod_fix;
  logic [PW-1:0]              rd_addr_r;
  logic [PW:0]                issue_cnt_r;
  logic [PW-1:0]              cmp_addr_r;
  logic [PW:0]                cmp_cnt_r;
  logic                       cmp_vld_r;
  logic                       free_found_r;
  logic [PW-1:0]              free_pos_r;
  logic [shtp_pkg::STATUS_W-1:0] res_status_r;
  logic [PW-1:0]              res_slot_r;
  logic                       out_vld_r;
  logic [31:0]                slot_ext;

  logic          hit;
  logic          scan_end;
  logic          free_any;
  logic [PW-1:0] free_sel;
  logic          vld_we;
  logic          vld_wdata;
  logic [PW-1:0] vld_waddr;
  logic          chk_we;
  logic          out_load;

  // The estimated remainder lies below twice the depth, so one subtract fixes it.
  assign mod_rem = mod_src_r - mod_qd_r;
  assign mod_fix = (mod_rem >= DEPTH_32) ? (mod_rem - DEPTH_32) : mod_rem;

  assign hit      = cmp_vld_r && vld_q
                 && (chk_q == {job_r.hash_a, job_r.hash_b});
  assign scan_end = cmp_vld_r && (hit || (cmp_cnt_r == CNT_LAST));
  assign free_any = free_found_r || (cmp_vld_r && !vld_q);
  assign free_sel = free_found_r ? free_pos_r : cmp_addr_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shtp_pkg::ST_CLEAR: begin
        if (clr_addr_r == LAST_POS) state_nxt = shtp_pkg::ST_IDLE;
      end
      shtp_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.empty_name ? shtp_pkg::ST_DONE : shtp_pkg::ST_MOD;
        end
      end
      shtp_pkg::ST_MOD: begin
        if (mod_cnt_r == MOD_LAST) state_nxt = shtp_pkg::ST_SCAN;
      end
      shtp_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = shtp_pkg::ST_DONE;
      end
      shtp_pkg::ST_DONE: begin
        if (!out_vld_r || out_pop) state_nxt = shtp_pkg::ST_IDLE;
      end
      default: state_nxt = shtp_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = 1'b0;
    clearing  = 1'b0;
    vld_we    = 1'b0;
    vld_wdata = 1'b0;
    vld_waddr = clr_addr_r;
    chk_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      shtp_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        vld_we   = 1'b1;
      end
      shtp_pkg::ST_IDLE: begin
        q_pop = !q_empty;
      end
      shtp_pkg::ST_SCAN: begin
        if (scan_end && !hit && job_r.op == shtp_pkg::OP_INSERT && free_any) begin
          vld_we    = 1'b1;
          vld_wdata = 1'b1;
          vld_waddr = free_sel;
          chk_we    = 1'b1;
        end
      end
      shtp_pkg::ST_DONE: begin
        out_load = !out_vld_r || out_pop;
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
    if (chk_we) begin
      chk_mem[free_sel] <= {job_r.hash_a, job_r.hash_b};
    end
    vld_q <= vld_mem[rd_addr_r];
    chk_q <= chk_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= shtp_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == shtp_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      cmp_vld_r <= (state_r == shtp_pkg::ST_SCAN) && !scan_end
                && (issue_cnt_r != DEPTH_W);
      if (state_r == shtp_pkg::ST_MOD) begin
        free_found_r <= 1'b0;
      end else if (cmp_vld_r && !vld_q && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r     <= q_data;
      mod_cnt_r <= '0;
      mod_src_r <= q_data.hash_slot;
      if (q_data.empty_name) begin
        res_status_r <= shtp_pkg::STATUS_EMPTY_NAME;
        res_slot_r   <= '0;
      end
    end
    // Reduction steps: reciprocal product, quotient times depth, final correction.
    if (state_r == shtp_pkg::ST_MOD) begin
      mod_cnt_r   <= mod_cnt_r + 1'b1;
      mod_prod_r  <= 64'(mod_src_r) * 64'(RECIP);
      mod_qd_r    <= mod_prod_r[2*shtp_pkg::HASH_W-1:shtp_pkg::HASH_W] * DEPTH_32;
      if (mod_cnt_r == MOD_LAST) begin
        rd_addr_r <= mod_fix[PW-1:0];
      end
      issue_cnt_r <= '0;
      cmp_cnt_r   <= '0;
    end
    if (state_r == shtp_pkg::ST_SCAN) begin
      if (issue_cnt_r != DEPTH_W) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
        rd_addr_r   <= (rd_addr_r == LAST_POS) ? '0 : rd_addr_r + 1'b1;
      end
      cmp_addr_r <= rd_addr_r;
      if (cmp_vld_r) begin
        cmp_cnt_r <= cmp_cnt_r + 1'b1;
      end
      if (cmp_vld_r && !vld_q && !free_found_r) begin
        free_pos_r <= cmp_addr_r;
      end
      if (scan_end) begin
        if (hit) begin
          res_status_r <= shtp_pkg::STATUS_FOUND;
          res_slot_r   <= cmp_addr_r;
        end else if (job_r.op == shtp_pkg::OP_INSERT && free_any) begin
          res_status_r <= shtp_pkg::STATUS_INSERTED;
          res_slot_r   <= free_sel;
        end else if (job_r.op == shtp_pkg::OP_INSERT) begin
          res_status_r <= shtp_pkg::STATUS_FULL;
          res_slot_r   <= '0;
        end else begin
          res_status_r <= shtp_pkg::STATUS_NOT_FOUND;
          res_slot_r   <= '0;
        end
      end
    end
  end

  assign slot_ext = 32'(res_slot_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status_r;
      out_slot   <= slot_ext[shtp_pkg::SLOT_W-1:0];
      if (job_r.empty_name) begin
        out_slot_hash    <= '0;
        out_check_hash_a <= '0;
        out_check_hash_b <= '0;
      end else begin
        out_slot_hash    <= job_r.hash_slot;
        out_check_hash_a <= job_r.hash_a;
        out_check_hash_b <= job_r.hash_b;
      end
    end
  end

  assign out_empty = !out_vld_r;

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shtp_pkg::ST_CLEAR) |-> !out_vld_r)
    else $error("result present during table clear");

  a_compare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shtp_pkg::ST_SCAN && cmp_vld_r) |-> (cmp_cnt_r < DEPTH_W))
    else $error("scan compared more entries than the table holds");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == shtp_pkg::ST_MOD || state_r == shtp_pkg::ST_DONE))
    else $error("request taken without starting a job");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_string_hash_table_probe.sv =====
// ----------------------------------------------------------------------------
// String hash table probe: testbench
// Sends names one byte per item: a few directed ones, then random and repeated
// names and stray bytes, then more directed ones. A scoreboard tracks the hashes
// and the table contents and checks every result field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_string_hash_table_probe;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int MAX_NAME   = 8;

  typedef struct {
    shtp_pkg::status_t           status;
    logic [shtp_pkg::SLOT_W-1:0] slot;
    logic [shtp_pkg::HASH_W-1:0] slot_hash;
    logic [shtp_pkg::HASH_W-1:0] hash_a;
    logic [shtp_pkg::HASH_W-1:0] hash_b;
  } probe_result_t;

  class probe_scoreboard;
    logic [shtp_pkg::HASH_W-1:0] rom [1024];
    logic [shtp_pkg::HASH_W-1:0] s1 [3];
    logic [shtp_pkg::HASH_W-1:0] s2 [3];
    bit                          seen;
    bit                          used [DEPTH];
    logic [shtp_pkg::HASH_W-1:0] tab_a [DEPTH];
    logic [shtp_pkg::HASH_W-1:0] tab_b [DEPTH];
    probe_result_t               pending [$];
    int                          errors;

    function new();
      longint unsigned s;
      longint unsigned hi;
      s = 64'h00100001;
      for (int c = 0; c < 256; c++) begin
        for (int k = 0; k < 4; k++) begin
          s  = (s * 125 + 3) % 64'h2AAAAB;
          hi = s & 64'hFFFF;
          s  = (s * 125 + 3) % 64'h2AAAAB;
          rom[k * 256 + c] = {hi[15:0], s[15:0]};
        end
      end
      foreach (used[i]) used[i] = 0;
      clear_name();
      errors = 0;
    endfunction

    function void clear_name();
      for (int i = 0; i < 3; i++) begin
        s1[i] = 32'h7FED7FED;
        s2[i] = 32'hEEEEEEEE;
      end
      seen = 0;
    endfunction

    // Lanes 0, 1, 2 use crypt kinds A (1), B (2) and slot (3).
    function void take_byte(shtp_pkg::op_t op, logic [7:0] ch, logic last);
      probe_result_t r;
      int            pos;
      logic [31:0]   c32;
      c32 = {24'd0, ch};
      if (ch != 0) begin
        for (int i = 0; i < 3; i++) begin
          s1[i] = rom[(i + 1) * 256 + ch] ^ (s1[i] + s2[i]);
          s2[i] = c32 + s1[i] + s2[i] + (s2[i] << 5) + 32'd3;
        end
        seen = 1;
      end
      if (!last) return;
      if (!seen) begin
        r = '{shtp_pkg::STATUS_EMPTY_NAME, '0, '0, '0, '0};
      end else begin
        r = '{shtp_pkg::STATUS_NOT_FOUND, '0, s1[2], s1[0], s1[1]};
        pos = s1[2] % DEPTH;
        for (int n = 0; n < DEPTH; n++) begin
          if (used[pos] && tab_a[pos] == r.hash_a && tab_b[pos] == r.hash_b) begin
            r.status = shtp_pkg::STATUS_FOUND;
            r.slot   = shtp_pkg::SLOT_W'(pos);
            break;
          end
          pos = (pos + 1) % DEPTH;
        end
        if (r.status == shtp_pkg::STATUS_NOT_FOUND && op == shtp_pkg::OP_INSERT) begin
          r.status = shtp_pkg::STATUS_FULL;
          pos = s1[2] % DEPTH;
          for (int n = 0; n < DEPTH; n++) begin
            if (!used[pos]) begin
              used[pos]  = 1;
              tab_a[pos] = r.hash_a;
              tab_b[pos] = r.hash_b;
              r.status   = shtp_pkg::STATUS_INSERTED;
              r.slot     = shtp_pkg::SLOT_W'(pos);
              break;
            end
            pos = (pos + 1) % DEPTH;
          end
        end
      end
      clear_name();
      pending.push_back(r);
    endfunction

    function void check_result(probe_result_t got);
      probe_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d slot %0d", got.status, got.slot);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.slot_hash !== want.slot_hash || got.hash_a !== want.hash_a ||
          got.hash_b !== want.hash_b) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected st %0d slot %0d hs %h a %h b %h", want.status,
                   want.slot, want.slot_hash, want.hash_a, want.hash_b);
          $display("          actual   st %0d slot %0d hs %h a %h b %h", got.status,
                   got.slot, got.slot_hash, got.hash_a, got.hash_b);
        end
      end
    endfunction
  endclass

  logic                          clk = 0;
  logic                          rst_n = 0;
  logic                          in_push = 0;
  logic                          in_full;
  logic                          in_opcode = 0;
  logic [shtp_pkg::BYTE_W-1:0]   in_name_byte = '0;
  logic                          in_last = 0;
  logic                          out_empty;
  logic                          out_pop = 0;
  logic [shtp_pkg::STATUS_W-1:0] out_status;
  logic [shtp_pkg::SLOT_W-1:0]   out_slot;
  logic [shtp_pkg::HASH_W-1:0]   out_slot_hash;
  logic [shtp_pkg::HASH_W-1:0]   out_check_hash_a;
  logic [shtp_pkg::HASH_W-1:0]   out_check_hash_b;

  probe_scoreboard sb = new();
  int              idle_cycles = 0;
  int              items_sent = 0;
  int              burst_left = 0;
  int              pop_mode = 0;
  int              pop_mode_left = 0;
  logic [63:0]     known_names [$];
  int              known_lens [$];

  string_hash_table_probe #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_name_byte(in_name_byte), .in_last(in_last),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_status(out_status), .out_slot(out_slot), .out_slot_hash(out_slot_hash),
    .out_check_hash_a(out_check_hash_a), .out_check_hash_b(out_check_hash_b)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_push && !in_full) begin
        sb.take_byte(shtp_pkg::op_t'(in_opcode), in_name_byte, in_last);
      end
      if (out_pop && !out_empty) begin
        sb.check_result('{shtp_pkg::status_t'(out_status), out_slot, out_slot_hash,
                          out_check_hash_a, out_check_hash_b});
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // The receiver switches between always ready, coin flips and long stalls.
  always @(negedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode      <= $urandom_range(0, 2);
      pop_mode_left <= $urandom_range(1, 300);
    end else begin
      pop_mode_left <= pop_mode_left - 1;
    end
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= 1'($urandom_range(0, 1));
      default: out_pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic push_byte(logic op, logic [7:0] ch, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
    burst_left--;
    in_push      <= 1'b1;
    in_opcode    <= op;
    in_name_byte <= ch;
    in_last      <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Bytes are packed low byte first; the opcode rides on every byte.
  task automatic send_name(logic [63:0] name, int len, logic op);
    for (int i = 0; i < len; i++) begin
      push_byte(op, name[8*i +: 8], i == len - 1);
    end
  endtask

  task automatic send_random_name();
    logic [63:0] name;
    int          len;
    len = $urandom_range(1, MAX_NAME);
    name = {$urandom, $urandom};
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) name[8*i +: 8] = 8'h00;
    end
    known_names.push_back(name);
    known_lens.push_back(len);
    send_name(name, len, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int pick;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed names: empty, zero bytes, byte extremes, miss, insert, duplicate.
    send_name(64'h00, 1, shtp_pkg::OP_LOOKUP);
    send_name(64'h00, 1, shtp_pkg::OP_INSERT);
    send_name(64'h0000, 2, shtp_pkg::OP_INSERT);
    send_name(64'hFF, 1, shtp_pkg::OP_LOOKUP);
    send_name(64'hFF, 1, shtp_pkg::OP_INSERT);
    send_name(64'hFF, 1, shtp_pkg::OP_INSERT);
    send_name(64'hFF, 1, shtp_pkg::OP_LOOKUP);
    send_name(64'h00FF, 2, shtp_pkg::OP_LOOKUP);
    send_name(64'h80_01, 2, shtp_pkg::OP_INSERT);
    send_name(64'h80_00_01, 3, shtp_pkg::OP_LOOKUP);
    send_name(64'h01_80, 2, shtp_pkg::OP_LOOKUP);
    send_name(64'h55_AA_7F, 3, shtp_pkg::OP_INSERT);
    send_name(64'h55_AA_7F, 3, shtp_pkg::OP_LOOKUP);

    while (items_sent < 1000) begin
      pick = $urandom_range(0, 19);
      if (pick < 13 || known_names.size() == 0) begin
        send_random_name();
      end else if (pick < 19) begin
        pick = $urandom_range(0, known_names.size() - 1);
        send_name(known_names[pick], known_lens[pick], 1'($urandom_range(0, 1)));
      end else begin
        push_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
      end
    end

    send_name(64'h0102030405060708, 8, shtp_pkg::OP_LOOKUP);
    send_name(64'h0102030405060708, 8, shtp_pkg::OP_INSERT);
    send_name(64'h80_01, 2, shtp_pkg::OP_LOOKUP);

    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
